>>> design/srfr_pkg.sv
// Shared constants, codes and the result type of the servo response frame receiver.
`default_nettype none

package srfr_pkg;

    // Largest length field that a frame may carry before it is dropped.
    localparam int MAX_FRAME_LENGTH = 7;
    localparam int MIN_FRAME_LENGTH = 3;
    localparam int MAX_KEPT_PARAMS  = 4;

    // Widths that follow from the length limit.
    localparam int LEN_W = $clog2(MAX_FRAME_LENGTH + 1);
    localparam int IDX_W = $clog2(MAX_FRAME_LENGTH + 3);

    localparam logic [7:0] HDR_BYTE = 8'h55;

    // Frame positions of the fixed bytes.
    localparam logic [IDX_W-1:0] IDX_ID     = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LEN    = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CMD    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_PARAM0 = IDX_W'(5);

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  servo_id;
        logic [7:0]  command;
        logic [2:0]  param_count;
        logic [31:0] params;
    } result_t;

endpackage

`default_nettype wire

>>> design/srfr_deframer.sv
// Frame hunting, byte collection and checksum check for one received byte per cycle in which step is high.
`default_nettype none

module srfr_deframer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [4:0]      response_limit,
    output logic                 frame_end,
    output srfr_pkg::result_t    result
);
    import srfr_pkg::*;

    logic             header_seen_reg, header_seen_next;
    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       held_id_reg, held_id_next;
    logic [7:0]       held_command_reg, held_command_next;
    logic [31:0]      held_params_reg, held_params_next;

    logic             len_bad;
    logic             in_params;
    logic [7:0]       sum_plus;
    logic [LEN_W-1:0] count_full;
    logic [2:0]       count;
    logic [7:0]       limit_ext;
    logic [7:0]       length_ext;

    // The parameter bytes run up to the position just before the checksum.
    assign in_params = ({1'b0, byte_index_reg} < ((IDX_W+1)'(frame_length_reg) + (IDX_W+1)'(2)));
    assign len_bad   = (rx_byte < 8'(MIN_FRAME_LENGTH)) || (rx_byte > 8'(MAX_FRAME_LENGTH));
    assign sum_plus  = running_sum_reg + rx_byte;

    // The checksum byte ends the frame.
    assign frame_end = in_frame_reg && (byte_index_reg != IDX_ID) && (byte_index_reg != IDX_LEN)
                     && (byte_index_reg != IDX_CMD) && !in_params;

    // Parameter count saturates at the number of bytes that are kept.
    assign count_full = frame_length_reg - LEN_W'(MIN_FRAME_LENGTH);
    assign count = (count_full > LEN_W'(MAX_KEPT_PARAMS)) ? 3'(MAX_KEPT_PARAMS) : 3'(count_full);

    assign limit_ext  = 8'(response_limit);
    assign length_ext = 8'(frame_length_reg);

    // Result of the frame that ends with the current byte.
    always_comb begin
        result.servo_id    = held_id_reg;
        result.command     = held_command_reg;
        result.param_count = count;
        result.params      = held_params_reg;
        if (~running_sum_reg != rx_byte) begin
            result.status = STATUS_BAD_SUM;
        end else if (length_ext > limit_ext) begin
            result.status = STATUS_TOO_LONG;
        end else begin
            result.status = STATUS_OK;
        end
    end

    // Next state for one received byte.
    always_comb begin
        header_seen_next  = header_seen_reg;
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        held_id_next      = held_id_reg;
        held_command_next = held_command_reg;
        held_params_next  = held_params_reg;
        if (!in_frame_reg) begin
            if (rx_byte == HDR_BYTE) begin
                if (header_seen_reg) begin
                    header_seen_next  = 1'b0;
                    in_frame_next     = 1'b1;
                    byte_index_next   = IDX_ID;
                    frame_length_next = LEN_W'(2);
                    running_sum_next  = 8'd0;
                    held_id_next      = 8'd0;
                    held_command_next = 8'd0;
                    held_params_next  = 32'd0;
                end else begin
                    header_seen_next = 1'b1;
                end
            end else begin
                header_seen_next = 1'b0;
            end
        end else if (byte_index_reg == IDX_ID) begin
            held_id_next     = rx_byte;
            running_sum_next = rx_byte;
            byte_index_next  = IDX_LEN;
        end else if (byte_index_reg == IDX_LEN) begin
            if (len_bad) begin
                in_frame_next     = 1'b0;
                header_seen_next  = 1'b0;
                byte_index_next   = '0;
                frame_length_next = LEN_W'(2);
            end else begin
                frame_length_next = LEN_W'(rx_byte);
                running_sum_next  = sum_plus;
                byte_index_next   = IDX_CMD;
            end
        end else if (byte_index_reg == IDX_CMD) begin
            held_command_next = rx_byte;
            running_sum_next  = sum_plus;
            byte_index_next   = IDX_PARAM0;
        end else if (in_params) begin
            // Only the first few parameter bytes are kept; all enter the sum.
            for (int k = 0; k < MAX_KEPT_PARAMS; k++) begin
                if (byte_index_reg == IDX_PARAM0 + IDX_W'(k)) begin
                    held_params_next[8*k +: 8] = rx_byte;
                end
            end
            running_sum_next = sum_plus;
            byte_index_next  = byte_index_reg + IDX_W'(1);
        end else begin
            in_frame_next     = 1'b0;
            header_seen_next  = 1'b0;
            byte_index_next   = '0;
            frame_length_next = LEN_W'(2);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_seen_reg  <= 1'b0;
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= '0;
            frame_length_reg <= LEN_W'(2);
        end else if (step) begin
            header_seen_reg  <= header_seen_next;
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
        end
    end

    // Captured frame bytes and running checksum.
    always_ff @(posedge aclk) begin
        if (step) begin
            running_sum_reg  <= running_sum_next;
            held_id_reg      <= held_id_next;
            held_command_reg <= held_command_next;
            held_params_reg  <= held_params_next;
        end
    end

endmodule

`default_nettype wire

>>> design/servo_response_frame_receiver.sv
// Top level of the servo response frame receiver: beat registers, config register, deframer.
// Timing: a byte beat lands in the input register at its accepting edge; a frame's result is
// registered and valid on the m_ channel once its checksum byte steps on from the input register.
// Throughput: one byte beat per cycle, limited only by m_ready stalls when a frame ends.
// Reset (aresetn low, synchronous): hunting for a header, both registers empty,
// response_limit set to 6.
`default_nettype none

module servo_response_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_response_limit,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_servo_id,
    output logic [7:0]       m_command,
    output logic [2:0]       m_param_count,
    output logic [31:0]      m_params
);
    import srfr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [4:0] limit_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       frame_end;
    logic       out_free;
    logic       step;

    // A byte moves on unless it ends a frame while the result register is still full.
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && (!frame_end || out_free);
    assign s_ready   = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 5'd6;
        end else if (cfg_valid) begin
            limit_reg <= cfg_response_limit;
        end
    end

    // Input beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    srfr_deframer u_deframer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .rx_byte        (in_byte_reg),
        .response_limit (limit_reg),
        .frame_end      (frame_end),
        .result         (result)
    );

    // Result beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && frame_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && frame_end) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_servo_id    = out_reg.servo_id;
    assign m_command     = out_reg.command;
    assign m_param_count = out_reg.param_count;
    assign m_params      = out_reg.params;

    // A result waiting on a stalled output is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_valid_reg && !m_ready && step && frame_end))
        else $error("result overwritten while stalled");

    // A held byte that cannot move stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !s_ready) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

    // Status carries one of the three defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (m_status == STATUS_OK || m_status == STATUS_BAD_SUM
                           || m_status == STATUS_TOO_LONG))
        else $error("undefined status code");

    // Parameter count never exceeds the kept bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (m_param_count <= 3'(MAX_KEPT_PARAMS)))
        else $error("parameter count out of range");

endmodule

`default_nettype wire
